// ----- hw/rtl/xlsr_pkg.sv -----
// Package for the x86 logic, shift and rotate unit.
// Holds the port item types, operation and size codes, the decoded queue entry,
// and the shared width helpers. Depends on nothing.
`default_nettype none

package xlsr_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CountW     = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    OP_TEST = 4'd0,
    OP_AND  = 4'd1,
    OP_XOR  = 4'd2,
    OP_OR   = 4'd3,
    OP_NOT  = 4'd4,
    OP_SAR  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SHR  = 4'd7,
    OP_ROL  = 4'd8,
    OP_ROR  = 4'd9,
    OP_SHLD = 4'd10,
    OP_SHRD = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2
  } size_e;

  typedef struct packed {
    logic [3:0]       operation;
    logic [1:0]       size_code;
    logic [DataW-1:0] dest_value;
    logic [DataW-1:0] source_value;
    logic [DataW-1:0] second_source;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             write_back;
    logic             zero_out;
    logic             sign_out;
    logic             carry_out;
    logic             overflow_out;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    size_e             size;
    logic [DataW-1:0]  dest;
    logic [DataW-1:0]  src;
    logic [DataW-1:0]  fill;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] rot_n;
  } dec_t;

  function automatic logic [DataW-1:0] width_mask(size_e size);
    logic [DataW-1:0] m;
    case (size)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic msb_of(logic [DataW-1:0] v, size_e size);
    logic b;
    case (size)
      SZ_BYTE: b = v[7];
      SZ_WORD: b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  function automatic logic msb_next_of(logic [DataW-1:0] v, size_e size);
    logic b;
    case (size)
      SZ_BYTE: b = v[6];
      SZ_WORD: b = v[14];
      default: b = v[30];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/xlsr_front.sv -----
// Front end: decodes an incoming item into a queue entry.
// Normalizes the size, masks operands, extracts the count and rotate amount.
// Depends on xlsr_pkg.
`default_nettype none

module xlsr_front (
  input  wire xlsr_pkg::in_item_t in_item_i,
  output xlsr_pkg::dec_t          dec_o
);

  xlsr_pkg::size_e               size;
  logic [xlsr_pkg::DataW-1:0]    mask;
  logic [xlsr_pkg::CountW-1:0]   cnt;

  always_comb begin
    unique case (in_item_i.size_code)
      2'd0:    size = xlsr_pkg::SZ_BYTE;
      2'd1:    size = xlsr_pkg::SZ_WORD;
      default: size = xlsr_pkg::SZ_DWORD;
    endcase
  end

  assign mask = xlsr_pkg::width_mask(size);
  assign cnt  = in_item_i.source_value[xlsr_pkg::CountW-1:0];

  always_comb begin
    dec_o.op   = xlsr_pkg::op_e'(in_item_i.operation);
    dec_o.size = size;
    dec_o.dest = in_item_i.dest_value & mask;
    dec_o.src  = in_item_i.source_value & mask;
    dec_o.fill = in_item_i.second_source & mask;
    dec_o.cnt  = cnt;
    case (size)
      xlsr_pkg::SZ_BYTE: dec_o.rot_n = {2'b00, cnt[2:0]};
      xlsr_pkg::SZ_WORD: dec_o.rot_n = {1'b0, cnt[3:0]};
      default:           dec_o.rot_n = cnt;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/xlsr_queue.sv -----
// Short FIFO of decoded entries between the front and back ends.
// Depends on xlsr_pkg.
`default_nettype none

module xlsr_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire xlsr_pkg::dec_t     push_data_i,
  output logic                    full_o,
  input  wire                     pop_i,
  output xlsr_pkg::dec_t          head_o,
  output logic                    valid_o
);

  xlsr_pkg::dec_t                   entry_q [xlsr_pkg::QueueDepth];
  logic [xlsr_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [xlsr_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [xlsr_pkg::QueueCntW-1:0]   cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == xlsr_pkg::QueueCntW'(xlsr_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/xlsr_back.sv -----
// Back end: executes the queued entry, keeps the ZF/SF/CF/OF flags,
// and holds the result in an output register. Depends on xlsr_pkg.
`default_nettype none

module xlsr_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire xlsr_pkg::dec_t     head_i,
  input  wire                     head_valid_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output xlsr_pkg::out_item_t     out_item_o
);

  logic                       zf_q, sf_q, cf_q, of_q;
  logic                       zf_d, sf_d, cf_d, of_d;
  logic                       out_valid_q, out_valid_d;
  xlsr_pkg::out_item_t        out_q;
  xlsr_pkg::out_item_t        res_item;

  logic [xlsr_pkg::DataW-1:0] d, m, res, sx, sar_r;
  logic                       wb, cnt_nz, cf_rot;
  logic [15:0]                rl8, rr8, dl8, dr8;
  logic [31:0]                rl16, rr16, dl16, dr16;
  logic [63:0]                rl32, rr32, dl32, dr32;
  logic [xlsr_pkg::DataW-1:0] rol_r, ror_r, shld_r, shrd_r;

  assign d      = head_i.dest;
  assign m      = xlsr_pkg::width_mask(head_i.size);
  assign cnt_nz = (head_i.cnt != '0);

  always_comb begin
    case (head_i.size)
      xlsr_pkg::SZ_BYTE: sx = {{24{d[7]}}, d[7:0]};
      xlsr_pkg::SZ_WORD: sx = {{16{d[15]}}, d[15:0]};
      default:           sx = d;
    endcase
  end

  assign sar_r = $signed(sx) >>> head_i.cnt;

  always_comb begin
    rl8  = {d[7:0], d[7:0]} << head_i.rot_n[2:0];
    rr8  = {d[7:0], d[7:0]} >> head_i.rot_n[2:0];
    rl16 = {d[15:0], d[15:0]} << head_i.rot_n[3:0];
    rr16 = {d[15:0], d[15:0]} >> head_i.rot_n[3:0];
    rl32 = {d, d} << head_i.rot_n;
    rr32 = {d, d} >> head_i.rot_n;
    dl8  = {d[7:0], head_i.fill[7:0]} << head_i.cnt;
    dr8  = {head_i.fill[7:0], d[7:0]} >> head_i.cnt;
    dl16 = {d[15:0], head_i.fill[15:0]} << head_i.cnt;
    dr16 = {head_i.fill[15:0], d[15:0]} >> head_i.cnt;
    dl32 = {d, head_i.fill} << head_i.cnt;
    dr32 = {head_i.fill, d} >> head_i.cnt;
    case (head_i.size)
      xlsr_pkg::SZ_BYTE: begin
        rol_r  = {24'd0, rl8[15:8]};
        ror_r  = {24'd0, rr8[7:0]};
        shld_r = {24'd0, dl8[15:8]};
        shrd_r = {24'd0, dr8[7:0]};
      end
      xlsr_pkg::SZ_WORD: begin
        rol_r  = {16'd0, rl16[31:16]};
        ror_r  = {16'd0, rr16[15:0]};
        shld_r = {16'd0, dl16[31:16]};
        shrd_r = {16'd0, dr16[15:0]};
      end
      default: begin
        rol_r  = rl32[63:32];
        ror_r  = rr32[31:0];
        shld_r = dl32[63:32];
        shrd_r = dr32[31:0];
      end
    endcase
  end

  always_comb begin
    res    = d;
    wb     = 1'b1;
    zf_d   = zf_q;
    sf_d   = sf_q;
    cf_d   = cf_q;
    of_d   = of_q;
    cf_rot = 1'b0;
    unique case (head_i.op) inside
      xlsr_pkg::OP_TEST, xlsr_pkg::OP_AND, xlsr_pkg::OP_XOR, xlsr_pkg::OP_OR: begin
        if (head_i.op == xlsr_pkg::OP_XOR) begin
          res = d ^ head_i.src;
        end else if (head_i.op == xlsr_pkg::OP_OR) begin
          res = d | head_i.src;
        end else begin
          res = d & head_i.src;
        end
        wb   = (head_i.op != xlsr_pkg::OP_TEST);
        zf_d = (res == '0);
        sf_d = xlsr_pkg::msb_of(res, head_i.size);
        cf_d = 1'b0;
        of_d = 1'b0;
      end
      xlsr_pkg::OP_NOT: begin
        res = ~d & m;
      end
      xlsr_pkg::OP_SAR, xlsr_pkg::OP_SHL, xlsr_pkg::OP_SHR,
      xlsr_pkg::OP_SHLD, xlsr_pkg::OP_SHRD: begin
        if (cnt_nz) begin
          case (head_i.op)
            xlsr_pkg::OP_SHL:  res = (d << head_i.cnt) & m;
            xlsr_pkg::OP_SHR:  res = d >> head_i.cnt;
            xlsr_pkg::OP_SAR:  res = sar_r & m;
            xlsr_pkg::OP_SHLD: res = shld_r;
            default:           res = shrd_r;
          endcase
          zf_d = (res == '0);
          sf_d = xlsr_pkg::msb_of(res, head_i.size);
        end
      end
      xlsr_pkg::OP_ROL, xlsr_pkg::OP_ROR: begin
        if (cnt_nz) begin
          if (head_i.op == xlsr_pkg::OP_ROL) begin
            res    = rol_r;
            cf_rot = res[0];
            if (head_i.cnt == xlsr_pkg::CountW'(1)) begin
              of_d = xlsr_pkg::msb_of(res, head_i.size) ^ cf_rot;
            end
          end else begin
            res    = ror_r;
            cf_rot = xlsr_pkg::msb_of(res, head_i.size);
            if (head_i.cnt == xlsr_pkg::CountW'(1)) begin
              of_d = cf_rot ^ xlsr_pkg::msb_next_of(res, head_i.size);
            end
          end
          cf_d = cf_rot;
        end
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_item.result_value = res;
    res_item.write_back   = wb;
    res_item.zero_out     = zf_d;
    res_item.sign_out     = sf_d;
    res_item.carry_out    = cf_d;
    res_item.overflow_out = of_d;
  end

  assign pop_o       = head_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_d = pop_o | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zf_q        <= 1'b0;
      sf_q        <= 1'b0;
      cf_q        <= 1'b0;
      of_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        zf_q <= zf_d;
        sf_q <= sf_d;
        cf_q <= cf_d;
        of_q <= of_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/x86_logic_shift_rotate_unit_top.sv -----
// Top level of the x86 logic, shift and rotate unit.
// Instantiates xlsr_front, xlsr_queue and xlsr_back; uses xlsr_pkg.
//
// Accepts one instruction item per clock while in_ready_o is high and returns one
// result item per item, in order, carrying the result cut to operand width, the
// write-back bit and the ZF/SF/CF/OF flags after the instruction. Sustained rate
// is one item per cycle while out_ready_i is held high; each accepted item is
// written into the two-entry decode queue and is then executed from its head
// into the output register. The flags live in the execute stage and update as
// each item leaves the queue.
`default_nettype none

module x86_logic_shift_rotate_unit_top (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire xlsr_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output xlsr_pkg::out_item_t      out_item_o
);

  xlsr_pkg::dec_t dec;
  xlsr_pkg::dec_t head;
  logic           q_full, q_valid, q_pop;

  xlsr_front u_front (
    .in_item_i (in_item_i),
    .dec_o     (dec)
  );

  xlsr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (dec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head),
    .valid_o     (q_valid)
  );

  xlsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  assign in_ready_o = ~q_full;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for x86_logic_shift_rotate_unit_top: a directed table, then
// random instructions, each checked against its fixed expected row or an in-bench
// flag and result predictor. Depends on xlsr_pkg and the unit's top level only.

module testbench;

  localparam logic [3:0] OpUnusedLo = 4'd12;
  localparam logic [3:0] OpUnusedHi = 4'd15;
  localparam logic [1:0] SzUnused   = 2'd3;

  typedef struct {
    xlsr_pkg::in_item_t  item;
    bit                  fixed;
    xlsr_pkg::out_item_t want;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  xlsr_pkg::in_item_t  in_item_i   = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  xlsr_pkg::out_item_t out_item_o;

  logic      flag_zero     = 1'b0;
  logic      flag_sign     = 1'b0;
  logic      flag_carry    = 1'b0;
  logic      flag_overflow = 1'b0;

  bit                  cur_fixed = 1'b0;
  xlsr_pkg::out_item_t cur_want  = '0;
  bit                  quiet     = 1'b0;

  xlsr_pkg::out_item_t pending_results[$];
  stim_row_t           directed_rows[$];
  int                  mismatch_count = 0;
  xlsr_pkg::out_item_t predicted;
  xlsr_pkg::out_item_t want;

  x86_logic_shift_rotate_unit_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic xlsr_pkg::out_item_t exec_x86_op(xlsr_pkg::in_item_t it);
    int unsigned        w;
    logic [31:0]        m;
    logic [31:0]        d;
    logic [31:0]        s2;
    logic [31:0]        r;
    logic signed [31:0] sx;
    logic [63:0]        wide;
    logic [4:0]         cnt;
    int unsigned        n;
    logic               wb;
    w   = (it.size_code == xlsr_pkg::SZ_BYTE) ? 8 :
          (it.size_code == xlsr_pkg::SZ_WORD) ? 16 : 32;
    m   = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    d   = it.dest_value & m;
    s2  = it.second_source & m;
    cnt = it.source_value[4:0];
    r   = d;
    wb  = 1'b1;
    case (it.operation)
      xlsr_pkg::OP_TEST, xlsr_pkg::OP_AND, xlsr_pkg::OP_XOR, xlsr_pkg::OP_OR: begin
        if (it.operation == xlsr_pkg::OP_XOR) r = d ^ (it.source_value & m);
        else if (it.operation == xlsr_pkg::OP_OR) r = d | (it.source_value & m);
        else r = d & it.source_value & m;
        if (it.operation == xlsr_pkg::OP_TEST) wb = 1'b0;
        flag_zero     = (r == 32'h0);
        flag_sign     = r[w-1];
        flag_carry    = 1'b0;
        flag_overflow = 1'b0;
      end
      xlsr_pkg::OP_NOT: r = ~d & m;
      xlsr_pkg::OP_SAR, xlsr_pkg::OP_SHL, xlsr_pkg::OP_SHR: begin
        if (cnt != 5'd0) begin
          if (it.operation == xlsr_pkg::OP_SHL) begin
            r = (d << cnt) & m;
          end else if (it.operation == xlsr_pkg::OP_SHR) begin
            r = d >> cnt;
          end else begin
            sx = d | (d[w-1] ? ~m : 32'h0);
            sx = sx >>> cnt;
            r  = sx & m;
          end
          flag_zero = (r == 32'h0);
          flag_sign = r[w-1];
        end
      end
      xlsr_pkg::OP_ROL, xlsr_pkg::OP_ROR: begin
        if (cnt != 5'd0) begin
          n = cnt % w;
          if (n != 0) begin
            if (it.operation == xlsr_pkg::OP_ROL) r = ((d << n) | (d >> (w - n))) & m;
            else r = ((d >> n) | (d << (w - n))) & m;
          end
          if (it.operation == xlsr_pkg::OP_ROL) begin
            flag_carry = r[0];
            if (cnt == 5'd1) flag_overflow = r[w-1] ^ flag_carry;
          end else begin
            flag_carry = r[w-1];
            if (cnt == 5'd1) flag_overflow = r[w-1] ^ r[w-2];
          end
        end
      end
      xlsr_pkg::OP_SHLD, xlsr_pkg::OP_SHRD: begin
        if (cnt != 5'd0) begin
          if (it.operation == xlsr_pkg::OP_SHLD) begin
            wide = ({32'h0, d} << w) | {32'h0, s2};
            wide = (wide << cnt) >> w;
          end else begin
            wide = ({32'h0, s2} << w) | {32'h0, d};
            wide = wide >> cnt;
          end
          r         = wide[31:0] & m;
          flag_zero = (r == 32'h0);
          flag_sign = r[w-1];
        end
      end
      default: wb = 1'b0;
    endcase
    return {r, wb, flag_zero, flag_sign, flag_carry, flag_overflow};
  endfunction

  function automatic stim_row_t mk_row(logic [3:0] op, logic [1:0] sz, logic [31:0] d,
                                       logic [31:0] s, logic [31:0] s2, bit fixed,
                                       xlsr_pkg::out_item_t w);
    stim_row_t row;
    row.item  = {op, sz, d, s, s2};
    row.fixed = fixed;
    row.want  = w;
    return row;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input xlsr_pkg::in_item_t it, input bit fixed,
                           input xlsr_pkg::out_item_t w);
    int idle;
    idle = pick_gap();
    @(negedge clk_i);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    cur_fixed  <= fixed;
    cur_want   <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Predict on each accepted item, then check each delivered result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = exec_x86_op(in_item_i);
        pending_results.push_back(cur_fixed ? cur_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item %h", out_item_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.result_value !== want.result_value) begin
            $error("result_value: expected %h, got %h", want.result_value,
                   out_item_o.result_value);
            mismatch_count++;
          end
          if (out_item_o.write_back !== want.write_back) begin
            $error("write_back: expected %b, got %b", want.write_back, out_item_o.write_back);
            mismatch_count++;
          end
          if (out_item_o.zero_out !== want.zero_out) begin
            $error("zero_out: expected %b, got %b", want.zero_out, out_item_o.zero_out);
            mismatch_count++;
          end
          if (out_item_o.sign_out !== want.sign_out) begin
            $error("sign_out: expected %b, got %b", want.sign_out, out_item_o.sign_out);
            mismatch_count++;
          end
          if (out_item_o.carry_out !== want.carry_out) begin
            $error("carry_out: expected %b, got %b", want.carry_out, out_item_o.carry_out);
            mismatch_count++;
          end
          if (out_item_o.overflow_out !== want.overflow_out) begin
            $error("overflow_out: expected %b, got %b", want.overflow_out,
                   out_item_o.overflow_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stall the result side in random stretches.
  initial begin
    int stall;
    int run;
    forever begin
      stall = pick_gap();
      run   = $urandom_range(1, 20);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    xlsr_pkg::in_item_t it;
    logic [3:0]  op;
    logic [1:0]  sz;
    logic [31:0] d;
    logic [31:0] s;
    logic [4:0]  cnt;
    int unsigned w;
    int          roll;

    directed_rows.push_back(mk_row(xlsr_pkg::OP_NOT, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0000, 32'h0, 32'h0, 1'b1,
                                   {32'h0000_00FF, 5'b10000}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_TEST, xlsr_pkg::SZ_DWORD,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                   {32'hFFFF_FFFF, 5'b00100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_AND, xlsr_pkg::SZ_DWORD,
                                   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
                                   {32'h0000_0000, 5'b11000}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_XOR, xlsr_pkg::SZ_WORD,
                                   32'h0000_FFFF, 32'h0000_FFFF, 32'h0, 1'b1,
                                   {32'h0000_0000, 5'b11000}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_OR, xlsr_pkg::SZ_BYTE,
                                   32'hFFFF_FF80, 32'h0, 32'h0, 1'b1,
                                   {32'h0000_0080, 5'b10100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHL, xlsr_pkg::SZ_DWORD,
                                   32'h0000_0001, 32'd31, 32'h0, 1'b1,
                                   {32'h8000_0000, 5'b10100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHR, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0080, 32'd8, 32'h0, 1'b1,
                                   {32'h0000_0000, 5'b11000}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SAR, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0080, 32'd31, 32'h0, 1'b1,
                                   {32'h0000_00FF, 5'b10100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHL, xlsr_pkg::SZ_WORD,
                                   32'h0000_1234, 32'd32, 32'h0, 1'b1,
                                   {32'h0000_1234, 5'b10100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_ROL, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0081, 32'd1, 32'h0, 1'b1,
                                   {32'h0000_0003, 5'b10111}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_ROR, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0001, 32'd8, 32'h0, 1'b1,
                                   {32'h0000_0001, 5'b10101}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_ROL, xlsr_pkg::SZ_WORD,
                                   32'h0000_8000, 32'd16, 32'h0, 1'b1,
                                   {32'h0000_8000, 5'b10101}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_ROR, xlsr_pkg::SZ_DWORD,
                                   32'h0000_0001, 32'd1, 32'h0, 1'b1,
                                   {32'h8000_0000, 5'b10111}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHLD, xlsr_pkg::SZ_WORD,
                                   32'h0000_1234, 32'd20, 32'h0000_ABCD, 1'b1,
                                   {32'h0000_BCD0, 5'b10111}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHRD, xlsr_pkg::SZ_BYTE,
                                   32'h0000_005A, 32'd12, 32'h0000_00C3, 1'b1,
                                   {32'h0000_000C, 5'b10011}));
    directed_rows.push_back(mk_row(OpUnusedLo, xlsr_pkg::SZ_BYTE,
                                   32'h0000_01FF, 32'h0, 32'h0, 1'b1,
                                   {32'h0000_00FF, 5'b00011}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_AND, SzUnused,
                                   32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                   {32'h8000_0000, 5'b10100}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_TEST, xlsr_pkg::SZ_BYTE,
                                   32'h0000_0000, 32'h0000_00FF, 32'h0, 1'b1,
                                   {32'h0000_0000, 5'b01000}));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SAR, xlsr_pkg::SZ_WORD,
                                   32'h0000_8001, 32'd15, 32'h0, 1'b0, '0));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHL, xlsr_pkg::SZ_BYTE,
                                   32'h0000_00FF, 32'd1, 32'h0, 1'b0, '0));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHLD, xlsr_pkg::SZ_DWORD,
                                   32'hDEAD_BEEF, 32'd31, 32'h1234_5678, 1'b0, '0));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_SHRD, xlsr_pkg::SZ_DWORD,
                                   32'hCAFE_F00D, 32'd1, 32'h0F0F_0F0F, 1'b0, '0));
    directed_rows.push_back(mk_row(xlsr_pkg::OP_ROL, xlsr_pkg::SZ_DWORD,
                                   32'h8000_0001, 32'hFFFF_FFE1, 32'h0, 1'b0, '0));
    directed_rows.push_back(mk_row(OpUnusedHi, xlsr_pkg::SZ_WORD,
                                   32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, '0));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int chunk = 0; chunk < 13; chunk++) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(0, 99);
        op   = (roll < 5) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
        roll = $urandom_range(0, 99);
        sz   = (roll < 5) ? SzUnused : 2'($urandom_range(0, 2));
        w    = (sz == xlsr_pkg::SZ_BYTE) ? 8 : (sz == xlsr_pkg::SZ_WORD) ? 16 : 32;
        roll = $urandom_range(0, 9);
        d    = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
        s    = $urandom;
        if (op >= xlsr_pkg::OP_SAR) begin
          case ($urandom_range(0, 6))
            0: cnt = 5'd0;
            1: cnt = 5'd1;
            2: cnt = 5'(w - 1);
            3: cnt = 5'(w);
            4: cnt = 5'(w + 1);
            5: cnt = 5'd31;
            default: cnt = 5'($urandom_range(0, 31));
          endcase
          s[4:0] = cnt;
        end else if ($urandom_range(0, 9) == 0) begin
          s = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        it = {op, sz, d, s, 32'($urandom)};
        send_item(it, 1'b0, '0);
      end
      if (chunk == 5 || $urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
